[hdl/terq_pkg.sv]
// ----------------------------------------------------------------------------
// terq_pkg
// Shared types and constants for the timed event release queue.
// ----------------------------------------------------------------------------
package terq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 32;
  localparam int TIME_WIDTH_DEF    = 48;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // command selector on the input channel
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kinds on the output channel
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_SUM   = 2'd1;
  localparam logic [1:0] KIND_ADD   = 2'd2;
  localparam logic [1:0] KIND_DROP  = 2'd3;

  // operation broadcast along the cell chain
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_KEEP = 2'd2,
    MODE_DROP = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } cell_ctrl_t;

endpackage

[hdl/terq_cell.sv]
// ----------------------------------------------------------------------------
// terq_cell
// One queue slot: holds a due time and payload, loads a new event, takes its
// neighbour's entry on a shift, or takes the head entry when it is the tail.
// ----------------------------------------------------------------------------
module terq_cell
  import terq_pkg::*;
#(
  parameter int IDX           = 0,
  parameter int CW            = 6,
  parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [CW-1:0]            len,
  input  logic [TIME_WIDTH-1:0]    add_time,
  input  logic [PAYLOAD_WIDTH-1:0] add_pay,
  input  logic [TIME_WIDTH-1:0]    next_time,
  input  logic [PAYLOAD_WIDTH-1:0] next_pay,
  input  logic [TIME_WIDTH-1:0]    head_time,
  input  logic [PAYLOAD_WIDTH-1:0] head_pay,
  output logic [TIME_WIDTH-1:0]    slot_time,
  output logic [PAYLOAD_WIDTH-1:0] slot_pay
);

  logic [TIME_WIDTH-1:0]    time_r, time_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_nxt;
  logic                     is_at, is_inner, is_tail;

  assign is_at    = (len == CW'(IDX));
  assign is_inner = (CW'(IDX + 1) < len);
  assign is_tail  = (CW'(IDX + 1) == len);

  always_comb begin
    time_nxt = time_r;
    pay_nxt  = pay_r;
    unique case (ctrl.mode)
      MODE_ADD: begin
        if (is_at) begin
          time_nxt = add_time;
          pay_nxt  = add_pay;
        end
      end
      MODE_KEEP: begin
        if (is_inner) begin
          time_nxt = next_time;
          pay_nxt  = next_pay;
        end else if (is_tail) begin
          time_nxt = head_time;
          pay_nxt  = head_pay;
        end
      end
      MODE_DROP: begin
        if (is_inner) begin
          time_nxt = next_time;
          pay_nxt  = next_pay;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    pay_r  <= pay_nxt;
  end

  assign slot_time = time_r;
  assign slot_pay  = pay_r;

endmodule

[hdl/timed_event_release_queue.sv]
// ----------------------------------------------------------------------------
// timed_event_release_queue
// Bounded queue of timed events held in a chain of slot cells. Adds append at
// the tail; a tick rotates the chain through its head twice, first to count
// survivors and find the earliest one, then to release due entries in order
// and compact the rest.
// An add's result is registered and shown in the cycle after its transfer.
// A tick rotates every held entry through cell 0 in a scan pass and then a
// release pass, then a summary; release and summary steps wait on the output.
// One item is worked at a time; the next input is taken once it is finished.
// Reset (synchronous, active low) clears the control state, count, wake flag
// and output valid; slot contents stay undefined until written.
// ----------------------------------------------------------------------------
module timed_event_release_queue
  import terq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  localparam int CW      = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_FW   = 2 * TIME_WIDTH + PAYLOAD_WIDTH,
  localparam int IN_DW   = ((IN_FW + 7) / 8) * 8,
  localparam int OUT_FW  = PAYLOAD_WIDTH + 2 * TIME_WIDTH + 1 + CW,
  localparam int OUT_DW  = ((OUT_FW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // event_time, now_time, payload_handle
  input  logic [IN_DW-1:0]  in_tdata,
  // cmd
  input  logic [0:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // fired_payload, fired_time, next_delay, rearm, pending
  output logic [OUT_DW-1:0] out_tdata,
  // kind
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_RELEASE = 4'b0100,
    ST_SUMMARY = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            kept_r, kept_nxt;
  logic [CW-1:0]            step_r, step_nxt;
  logic [CW-1:0]            total_r, total_nxt;
  logic [TIME_WIDTH-1:0]    now_r, now_nxt;
  logic [TIME_WIDTH-1:0]    min_r, min_nxt;
  logic                     have_min_r, have_min_nxt;
  logic                     armed_r, armed_nxt;

  logic                     out_valid_r;
  logic [1:0]               out_kind_r;
  logic [OUT_FW-1:0]        out_data_r;
  logic                     out_last_r;

  logic                     in_cmd;
  logic [TIME_WIDTH-1:0]    in_ev_time, in_now;
  logic [PAYLOAD_WIDTH-1:0] in_pay;

  logic                     slot_free, acc, head_due, last_step;
  cell_ctrl_t               ctrl;

  logic                     emit;
  logic [1:0]               e_kind;
  logic [PAYLOAD_WIDTH-1:0] e_pay;
  logic [TIME_WIDTH-1:0]    e_time, e_delay;
  logic                     e_rearm, e_last;
  logic [CW-1:0]            e_pend;

  logic [TIME_WIDTH-1:0]    cell_time [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_pay  [QUEUE_DEPTH];

  assign in_cmd     = in_tuser[0];
  assign in_ev_time = in_tdata[TIME_WIDTH-1:0];
  assign in_now     = in_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
  assign in_pay     = in_tdata[IN_FW-1:2*TIME_WIDTH];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;
  assign head_due  = (cell_time[0] <= now_r);
  assign last_step = (step_r == total_r - CW'(1));

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [TIME_WIDTH-1:0]    nb_time;
    logic [PAYLOAD_WIDTH-1:0] nb_pay;
    if (g < QUEUE_DEPTH - 1) begin : g_nb
      assign nb_time = cell_time[g+1];
      assign nb_pay  = cell_pay[g+1];
    end else begin : g_end
      assign nb_time = '0;
      assign nb_pay  = '0;
    end
    terq_cell #(
      .IDX           (g),
      .CW            (CW),
      .TIME_WIDTH    (TIME_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .len       (count_r),
      .add_time  (in_ev_time),
      .add_pay   (in_pay),
      .next_time (nb_time),
      .next_pay  (nb_pay),
      .head_time (cell_time[0]),
      .head_pay  (cell_pay[0]),
      .slot_time (cell_time[g]),
      .slot_pay  (cell_pay[g])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    kept_nxt     = kept_r;
    step_nxt     = step_r;
    total_nxt    = total_r;
    now_nxt      = now_r;
    min_nxt      = min_r;
    have_min_nxt = have_min_r;
    armed_nxt    = armed_r;
    ctrl.mode    = MODE_NONE;
    emit         = 1'b0;
    e_kind       = KIND_SUM;
    e_pay        = '0;
    e_time       = '0;
    e_delay      = '0;
    e_rearm      = 1'b0;
    e_pend       = count_r;
    e_last       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_cmd == CMD_ADD) begin
            emit = 1'b1;
            if (count_r < CW'(QUEUE_DEPTH)) begin
              ctrl.mode = MODE_ADD;
              count_nxt = count_r + CW'(1);
              armed_nxt = 1'b1;
              e_kind    = KIND_ADD;
              e_rearm   = !armed_r;
              e_pend    = count_r + CW'(1);
            end else begin
              e_kind    = KIND_DROP;
            end
          end else begin
            now_nxt      = in_now;
            total_nxt    = count_r;
            step_nxt     = '0;
            kept_nxt     = '0;
            have_min_nxt = 1'b0;
            state_nxt    = (count_r == '0) ? ST_SUMMARY : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctrl.mode = MODE_KEEP;
        if (!head_due) begin
          kept_nxt = kept_r + CW'(1);
          if (!have_min_r || (cell_time[0] < min_r)) begin
            min_nxt      = cell_time[0];
            have_min_nxt = 1'b1;
          end
        end
        step_nxt = step_r + CW'(1);
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (slot_free) begin
          if (head_due) begin
            ctrl.mode = MODE_DROP;
            count_nxt = count_r - CW'(1);
            emit      = 1'b1;
            e_kind    = KIND_FIRED;
            e_pay     = cell_pay[0];
            e_time    = cell_time[0];
            e_pend    = kept_r;
            e_last    = 1'b0;
          end else begin
            ctrl.mode = MODE_KEEP;
          end
          step_nxt = step_r + CW'(1);
          if (last_step) begin
            state_nxt = ST_SUMMARY;
          end
        end
      end
      ST_SUMMARY: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_kind    = KIND_SUM;
          e_pend    = kept_r;
          e_rearm   = (kept_r != '0);
          e_delay   = (kept_r != '0) ? (min_r - now_r) : '0;
          armed_nxt = (kept_r != '0);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      kept_r      <= '0;
      step_r      <= '0;
      total_r     <= '0;
      have_min_r  <= 1'b0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      kept_r     <= kept_nxt;
      step_r     <= step_nxt;
      total_r    <= total_nxt;
      have_min_r <= have_min_nxt;
      armed_r    <= armed_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    min_r <= min_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_data_r <= {e_pend, e_rearm, e_delay, e_time, e_pay};
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
